### sv/prtf_pkg.sv
// Shared types and constants for the palette rotate / tone / fade block.
// No dependencies; used by prtf_shade and the top level.
`default_nettype none

package prtf_pkg;

    localparam int ENTRIES_DEF = 256;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_WRITE     = 2'd0,
        OP_READ      = 2'd1,
        OP_ROT_FIRST = 2'd2,
        OP_ROT_LAST  = 2'd3
    } op_t;

    // Configuration register indexes
    localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
    localparam logic [1:0] REG_FADE       = 2'd1;

    localparam logic [6:0] BRIGHTNESS_RST = 7'd0;
    localparam logic [8:0] FADE_RST       = 9'd256;

    // Tone curve: t = c + floor((b*c*(255-c) + HALF) / DEN)
    localparam logic [20:0] CURVE_DEN  = 21'd12750;
    localparam logic [20:0] CURVE_HALF = 21'd6375;
    localparam int          RECIP_SHIFT = 35;
    localparam logic [21:0] RECIP_MUL  = 22'((64'd1 << RECIP_SHIFT) / 64'd12750);

    typedef struct packed {
        logic       adv;
        logic [6:0] brightness;
        logic [8:0] fade;
    } shade_ctl_t;

endpackage

`default_nettype wire

### sv/prtf_mem.sv
// Palette store: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
`default_nettype none

module prtf_mem #(
    parameter int ENTRIES = 256,
    parameter int AW      = $clog2(ENTRIES)
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [23:0]   wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [23:0]   rdata
);

    logic [23:0] store_mem [ENTRIES];
    logic [23:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= store_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/prtf_shade.sv
// One channel of the tone curve and fade pipeline, five register stages.
// Depends on prtf_pkg (curve constants, control struct).
`default_nettype none

module prtf_shade (
    input  wire logic                clk,
    input  wire prtf_pkg::shade_ctl_t ctl,
    input  wire logic [7:0]          color,
    output logic      [7:0]          stored,
    output logic      [7:0]          shown
);

    logic [7:0]  c1_reg, c2_reg, c3_reg, c4_reg, c5_reg;
    logic [13:0] p1_reg;
    logic [20:0] x2_reg, x3_reg;
    logic [7:0]  qa3_reg;
    logic [7:0]  t4_reg;
    logic [7:0]  s5_reg;

    logic [13:0] p1_next;
    logic [20:0] x2_next;
    logic [42:0] recip_prod;
    logic [7:0]  qa3_next;
    logic [20:0] qd_prod;
    logic [20:0] rem;
    logic [8:0]  t_sum;
    logic [7:0]  t4_next;
    logic [16:0] fade_prod;
    logic [7:0]  s5_next;

    always_comb
    begin
        p1_next    = 14'(16'(color) * 16'(8'd255 - color));
        x2_next    = 21'(21'(ctl.brightness) * 21'(p1_reg)) + prtf_pkg::CURVE_HALF;
        recip_prod = 43'(x2_reg) * 43'(prtf_pkg::RECIP_MUL);
        qa3_next   = recip_prod[prtf_pkg::RECIP_SHIFT +: 8];
        // estimate is exact or one low; one compare fixes it
        qd_prod    = 21'(qa3_reg) * prtf_pkg::CURVE_DEN;
        rem        = x3_reg - qd_prod;
        t_sum      = 9'(c3_reg) + 9'(qa3_reg) + 9'(rem >= prtf_pkg::CURVE_DEN);
        t4_next    = t_sum[8] ? 8'd255 : t_sum[7:0];
        fade_prod  = 17'(t4_reg) * 17'(ctl.fade);
        s5_next    = fade_prod[16] ? 8'd255 : fade_prod[15:8];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            c1_reg  <= color;
            p1_reg  <= p1_next;
            c2_reg  <= c1_reg;
            x2_reg  <= x2_next;
            c3_reg  <= c2_reg;
            x3_reg  <= x2_reg;
            qa3_reg <= qa3_next;
            c4_reg  <= c3_reg;
            t4_reg  <= t4_next;
            c5_reg  <= c4_reg;
            s5_reg  <= s5_next;
        end
    end

    assign stored = c5_reg;
    assign shown  = s5_reg;

endmodule

`default_nettype wire

### sv/palette_rotate_tone_fade.sv
// Top level: palette store with range rotation, tone curve and fade.
// Depends on prtf_pkg, prtf_mem and prtf_shade.
//
//  channel | handshake                 | payload
//  --------+---------------------------+-----------------------------------------
//  in      | in_valid / in_stall       | operation, first_index, last_index, rgb
//  out     | out_valid / out_stall     | stored_*, shown_* (one item per read)
//  cfg     | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// Writes and reads may follow back to back while the output does not stall; a
// read result passes the registered memory read, then the curve pipeline.
// A rotation holds in_stall until it has walked its range: the single read and
// single write port of the store move one entry per cycle.
// rst_n clears control and configuration; palette contents are not cleared.
// out_stall with out_valid high freezes the whole result pipeline and stalls the input.
`default_nettype none

module palette_rotate_tone_fade #(
    parameter int ENTRIES = prtf_pkg::ENTRIES_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] operation,
    input  wire logic [7:0] first_index,
    input  wire logic [7:0] last_index,
    input  wire logic [7:0] red,
    input  wire logic [7:0] green,
    input  wire logic [7:0] blue,

    output logic            out_valid,
    input  wire logic       out_stall,
    output logic      [7:0] stored_red,
    output logic      [7:0] stored_green,
    output logic      [7:0] stored_blue,
    output logic      [7:0] shown_red,
    output logic      [7:0] shown_green,
    output logic      [7:0] shown_blue,

    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [8:0] cfg_data
);

    localparam int AW = $clog2(ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEEP,
        ST_MOVE,
        ST_LAST
    } state_t;

    state_t      state_reg;
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg, end_reg;
    logic        dir_reg;      // 1: pointers count up
    logic [23:0] keep_reg;
    logic [6:0]  brightness_reg;
    logic [8:0]  fade_reg;
    logic        s0_vld_reg, oor_reg;
    logic [4:0]  vld_reg;

    logic          accept, adv;
    logic          first_ok, last_ok, rot_ok;
    logic [AW-1:0] first_a, last_a, start_a;
    logic [AW-1:0] wr_step, rd_step;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [23:0]   mem_wdata, mem_rdata, color0;
    prtf_pkg::op_t op;
    prtf_pkg::shade_ctl_t ctl;

    assign op       = prtf_pkg::op_t'(operation);
    assign adv      = !(out_valid && out_stall);
    assign in_stall = (state_reg != ST_IDLE) || !adv;
    assign accept   = in_valid && !in_stall;

    assign first_ok = 32'(first_index) < ENTRIES;
    assign last_ok  = 32'(last_index) < ENTRIES;
    assign rot_ok   = (first_index < last_index) && last_ok;
    assign first_a  = AW'(first_index);
    assign last_a   = AW'(last_index);
    assign start_a  = (op == prtf_pkg::OP_ROT_FIRST) ? first_a : last_a;
    assign wr_step  = dir_reg ? wr_ptr_reg + AW'(1) : wr_ptr_reg - AW'(1);
    assign rd_step  = dir_reg ? rd_ptr_reg + AW'(1) : rd_ptr_reg - AW'(1);

    // memory port steering
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = wr_ptr_reg;
        mem_raddr = rd_ptr_reg;
        mem_wdata = mem_rdata;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        prtf_pkg::OP_WRITE:
                        begin
                            mem_we    = first_ok;
                            mem_waddr = first_a;
                            mem_wdata = {red, green, blue};
                        end
                        prtf_pkg::OP_READ:
                        begin
                            mem_re    = first_ok;
                            mem_raddr = first_a;
                        end
                        default:
                        begin
                            mem_re    = rot_ok;
                            mem_raddr = start_a;
                        end
                    endcase
                end
            end
            ST_KEEP:
            begin
                mem_re = 1'b1;
            end
            ST_MOVE:
            begin
                mem_we = 1'b1;
                mem_re = (wr_step != end_reg);
            end
            ST_LAST:
            begin
                mem_we    = 1'b1;
                mem_waddr = end_reg;
                mem_wdata = keep_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // rotation sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (op == prtf_pkg::OP_ROT_FIRST || op == prtf_pkg::OP_ROT_LAST)
                        && rot_ok)
                    begin
                        state_reg <= ST_KEEP;
                    end
                end
                ST_KEEP:
                begin
                    state_reg <= ST_MOVE;
                end
                ST_MOVE:
                begin
                    if (wr_step == end_reg)
                    begin
                        state_reg <= ST_LAST;
                    end
                end
                ST_LAST:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // rotation pointers, payload only
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                wr_ptr_reg <= start_a;
                dir_reg    <= (op == prtf_pkg::OP_ROT_FIRST);
                end_reg    <= (op == prtf_pkg::OP_ROT_FIRST) ? last_a : first_a;
                rd_ptr_reg <= (op == prtf_pkg::OP_ROT_FIRST) ? first_a + AW'(1)
                                                             : last_a - AW'(1);
            end
            ST_KEEP:
            begin
                keep_reg   <= mem_rdata;
                rd_ptr_reg <= rd_step;
            end
            ST_MOVE:
            begin
                wr_ptr_reg <= wr_step;
                rd_ptr_reg <= rd_step;
            end
            default:
            begin
                keep_reg <= keep_reg;
            end
        endcase
    end

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= prtf_pkg::BRIGHTNESS_RST;
            fade_reg       <= prtf_pkg::FADE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == prtf_pkg::REG_BRIGHTNESS)
            begin
                brightness_reg <= cfg_data[6:0];
            end
            else if (cfg_index == prtf_pkg::REG_FADE)
            begin
                fade_reg <= cfg_data;
            end
        end
    end

    // result valid chain; an out-of-range read flows through as black
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            oor_reg    <= 1'b0;
            vld_reg    <= '0;
        end
        else if (adv)
        begin
            s0_vld_reg <= accept && (op == prtf_pkg::OP_READ);
            oor_reg    <= !first_ok;
            vld_reg    <= {vld_reg[3:0], s0_vld_reg};
        end
    end

    assign out_valid = vld_reg[4];
    assign color0    = oor_reg ? 24'd0 : mem_rdata;

    assign ctl.adv        = adv;
    assign ctl.brightness = brightness_reg;
    assign ctl.fade       = fade_reg;

    prtf_mem #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    prtf_shade u_shade_r (
        .clk    (clk),
        .ctl    (ctl),
        .color  (color0[23:16]),
        .stored (stored_red),
        .shown  (shown_red)
    );

    prtf_shade u_shade_g (
        .clk    (clk),
        .ctl    (ctl),
        .color  (color0[15:8]),
        .stored (stored_green),
        .shown  (shown_green)
    );

    prtf_shade u_shade_b (
        .clk    (clk),
        .ctl    (ctl),
        .color  (color0[7:0]),
        .stored (stored_blue),
        .shown  (shown_blue)
    );

    // read data must hold while a read item waits to enter the curve pipeline
    a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s0_vld_reg && !adv) |-> !mem_re)
        else $error("read data overwritten under a waiting item");

    // no item is taken while a rotation is walking the store
    a_rot_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !accept)
        else $error("item accepted during rotation");

    // a move never writes the entry that is being read in the same cycle
    a_move_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOVE && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("rotation read and write collide");

    // the move phase ends before the write pointer reaches the range end
    a_move_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOVE) |-> (wr_ptr_reg != end_reg))
        else $error("rotation write pointer overran range");

endmodule

`default_nettype wire

### test/tb_palette_rotate_tone_fade.sv
// Self-checking testbench for palette_rotate_tone_fade: directed table, then random
// phases under several tone/fade settings, checked against a behavioral palette model.
// Depends on prtf_pkg and the palette_rotate_tone_fade RTL.
module tb_palette_rotate_tone_fade;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          QUIET_LIMIT = 4000;
    localparam int          ROT_SETTLE  = prtf_pkg::ENTRIES_DEF + 16;
    localparam int          SEGMENTS    = 6;
    localparam int          SEG_ITEMS   = 93;
    localparam logic [1:0]  REG_UNUSED  = 2'd3;

    // stored r,g,b then shown r,g,b
    typedef logic [0:5][7:0] pix_result_t;

    typedef struct packed {
        prtf_pkg::op_t op;
        logic [7:0]    first;
        logic [7:0]    last;
        logic [7:0]    r;
        logic [7:0]    g;
        logic [7:0]    b;
        logic          typed;
        pix_result_t   want;
    } dir_row_t;

    // Reads at reset tone settings: shown equals stored
    localparam dir_row_t DIRECTED [0:22] = '{
        '{prtf_pkg::OP_WRITE,     8'd0,   8'hff, 8'hff, 8'h00, 8'h80, 1'b0, 48'h0},
        '{prtf_pkg::OP_WRITE,     8'd255, 8'h00, 8'h00, 8'hff, 8'h7f, 1'b0, 48'h0},
        '{prtf_pkg::OP_READ,      8'd0,   8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 48'hff0080ff0080},
        '{prtf_pkg::OP_READ,      8'd255, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 48'h00ff7f00ff7f},
        '{prtf_pkg::OP_WRITE,     8'd1,   8'd0,  8'h11, 8'h22, 8'h33, 1'b0, 48'h0},
        '{prtf_pkg::OP_WRITE,     8'd2,   8'd0,  8'h44, 8'h55, 8'h66, 1'b0, 48'h0},
        '{prtf_pkg::OP_WRITE,     8'd3,   8'd0,  8'h77, 8'h88, 8'h99, 1'b0, 48'h0},
        '{prtf_pkg::OP_ROT_FIRST, 8'd0,   8'd3,  8'h00, 8'h00, 8'h00, 1'b0, 48'h0},
        '{prtf_pkg::OP_READ,      8'd0,   8'd0,  8'h00, 8'h00, 8'h00, 1'b1, 48'h112233112233},
        '{prtf_pkg::OP_READ,      8'd3,   8'd0,  8'h00, 8'h00, 8'h00, 1'b1, 48'hff0080ff0080},
        '{prtf_pkg::OP_ROT_LAST,  8'd0,   8'd3,  8'h00, 8'h00, 8'h00, 1'b0, 48'h0},
        '{prtf_pkg::OP_READ,      8'd0,   8'd0,  8'h00, 8'h00, 8'h00, 1'b1, 48'hff0080ff0080},
        '{prtf_pkg::OP_READ,      8'd1,   8'd0,  8'h00, 8'h00, 8'h00, 1'b1, 48'h112233112233},
        '{prtf_pkg::OP_ROT_FIRST, 8'd3,   8'd1,  8'h00, 8'h00, 8'h00, 1'b0, 48'h0},
        '{prtf_pkg::OP_READ,      8'd3,   8'd0,  8'h00, 8'h00, 8'h00, 1'b1, 48'h778899778899},
        '{prtf_pkg::OP_ROT_LAST,  8'd2,   8'd2,  8'h00, 8'h00, 8'h00, 1'b0, 48'h0},
        '{prtf_pkg::OP_READ,      8'd2,   8'd0,  8'h00, 8'h00, 8'h00, 1'b1, 48'h445566445566},
        '{prtf_pkg::OP_ROT_FIRST, 8'd254, 8'd255, 8'h00, 8'h00, 8'h00, 1'b0, 48'h0},
        '{prtf_pkg::OP_READ,      8'd254, 8'd0,  8'h00, 8'h00, 8'h00, 1'b1, 48'h00ff7f00ff7f},
        '{prtf_pkg::OP_ROT_LAST,  8'd254, 8'd255, 8'h00, 8'h00, 8'h00, 1'b0, 48'h0},
        '{prtf_pkg::OP_READ,      8'd255, 8'd0,  8'h00, 8'h00, 8'h00, 1'b1, 48'h00ff7f00ff7f},
        '{prtf_pkg::OP_WRITE,     8'd0,   8'd0,  8'h00, 8'h00, 8'h00, 1'b0, 48'h0},
        '{prtf_pkg::OP_READ,      8'd0,   8'd0,  8'h00, 8'h00, 8'h00, 1'b1, 48'h0}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;

    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] operation = prtf_pkg::OP_WRITE;
    logic [7:0] first_index = 8'd0;
    logic [7:0] last_index = 8'd0;
    logic [7:0] red = 8'd0;
    logic [7:0] green = 8'd0;
    logic [7:0] blue = 8'd0;

    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] stored_red;
    logic [7:0] stored_green;
    logic [7:0] stored_blue;
    logic [7:0] shown_red;
    logic [7:0] shown_green;
    logic [7:0] shown_blue;

    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = prtf_pkg::REG_BRIGHTNESS;
    logic [8:0] cfg_data = 9'd0;

    // palette model and tone settings
    logic [23:0] pal_model [0:prtf_pkg::ENTRIES_DEF-1];
    bit          pal_written [0:prtf_pkg::ENTRIES_DEF-1];
    logic [6:0]  bright_q = prtf_pkg::BRIGHTNESS_RST;
    logic [8:0]  fade_q = prtf_pkg::FADE_RST;

    pix_result_t pending_reads [$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    int          send_gap_pct = 0;
    int          recv_idle_pct = 0;
    pix_result_t got_pix;
    pix_result_t want_pix;
    string       field_names [0:5] = '{"stored_red", "stored_green", "stored_blue",
                                       "shown_red", "shown_green", "shown_blue"};

    palette_rotate_tone_fade #(.ENTRIES(prtf_pkg::ENTRIES_DEF)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .first_index  (first_index),
        .last_index   (last_index),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .stored_red   (stored_red),
        .stored_green (stored_green),
        .stored_blue  (stored_blue),
        .shown_red    (shown_red),
        .shown_green  (shown_green),
        .shown_blue   (shown_blue),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic [7:0] tone_fade(input logic [7:0] c);
        int unsigned cu;
        int unsigned t;
        int unsigned s;
        cu = c;
        t = (prtf_pkg::CURVE_DEN * cu + bright_q * cu * (255 - cu) + prtf_pkg::CURVE_HALF)
            / prtf_pkg::CURVE_DEN;
        if (t > 255)
            t = 255;
        s = (t * fade_q) >> 8;
        if (s > 255)
            s = 255;
        return s[7:0];
    endfunction

    task automatic palette_op(input prtf_pkg::op_t op, input logic [7:0] fi,
                              input logic [7:0] li,
                              input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              output bit has_res, output pix_result_t res);
        logic [23:0] keep;
        bit          keep_w;
        int          i;
        has_res = 1'b0;
        res = '0;
        case (op)
            prtf_pkg::OP_WRITE:
            begin
                pal_model[fi] = {r, g, b};
                pal_written[fi] = 1'b1;
            end
            prtf_pkg::OP_READ:
            begin
                has_res = 1'b1;
                res[0] = pal_model[fi][23:16];
                res[1] = pal_model[fi][15:8];
                res[2] = pal_model[fi][7:0];
                res[3] = tone_fade(res[0]);
                res[4] = tone_fade(res[1]);
                res[5] = tone_fade(res[2]);
            end
            prtf_pkg::OP_ROT_FIRST:
            begin
                if (fi <= li)
                begin
                    keep = pal_model[fi];
                    keep_w = pal_written[fi];
                    for (i = int'(fi); i < int'(li); i++)
                    begin
                        pal_model[i] = pal_model[i + 1];
                        pal_written[i] = pal_written[i + 1];
                    end
                    pal_model[li] = keep;
                    pal_written[li] = keep_w;
                end
            end
            default:
            begin
                if (fi <= li)
                begin
                    keep = pal_model[li];
                    keep_w = pal_written[li];
                    for (i = int'(li); i > int'(fi); i--)
                    begin
                        pal_model[i] = pal_model[i - 1];
                        pal_written[i] = pal_written[i - 1];
                    end
                    pal_model[fi] = keep;
                    pal_written[fi] = keep_w;
                end
            end
        endcase
    endtask

    // Leaves in_valid high on return; the caller lowers it when the stream ends.
    task automatic send_item(input prtf_pkg::op_t op, input logic [7:0] fi,
                             input logic [7:0] li,
                             input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic typed, input pix_result_t want);
        bit          has_res;
        pix_result_t res;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        first_index <= fi;
        last_index  <= li;
        red         <= r;
        green       <= g;
        blue        <= b;
        do
            @(posedge clk);
        while (in_stall);
        palette_op(op, fi, li, r, g, b, has_res, res);
        if (has_res)
            pending_reads.push_back(typed ? want : res);
    endtask

    task automatic send_random();
        int            pick;
        int            shape;
        int            top;
        int            k;
        prtf_pkg::op_t op;
        logic [7:0]    fi;
        logic [7:0]    li;
        pick = $urandom_range(99);
        fi = 8'($urandom_range(255));
        li = 8'($urandom_range(255));
        if (pick < 40)
            op = prtf_pkg::OP_WRITE;
        else if (pick < 75)
            op = prtf_pkg::OP_READ;
        else if (pick < 88)
            op = prtf_pkg::OP_ROT_FIRST;
        else
            op = prtf_pkg::OP_ROT_LAST;
        if (op == prtf_pkg::OP_READ)
        begin
            // never touch an entry that holds nothing yet
            for (k = 0; k < prtf_pkg::ENTRIES_DEF && !pal_written[fi]; k++)
                fi = fi + 8'd1;
        end
        else if (op != prtf_pkg::OP_WRITE)
        begin
            shape = $urandom_range(99);
            if (shape < 5)
            begin
                fi = 8'd0;
                li = 8'(prtf_pkg::ENTRIES_DEF - 1);
            end
            else if (shape < 15)
            begin
                fi = 8'($urandom_range(255, 1));
                li = 8'($urandom_range(int'(fi) - 1));
            end
            else if (shape < 22)
                li = fi;
            else
            begin
                top = int'(fi) + $urandom_range(15, 1);
                li = (top > 255) ? 8'd255 : 8'(top);
            end
        end
        send_item(op, fi, li, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
    endtask

    task automatic program_tone(input logic [6:0] bright, input logic [8:0] fade);
        cfg_valid <= 1'b1;
        cfg_index <= prtf_pkg::REG_BRIGHTNESS;
        cfg_data  <= {2'($urandom_range(3)), bright};
        do
            @(posedge clk);
        while (!cfg_ready);
        bright_q = bright;
        cfg_index <= prtf_pkg::REG_FADE;
        cfg_data  <= fade;
        do
            @(posedge clk);
        while (!cfg_ready);
        fade_q = fade;
        // unmapped index: no effect expected
        cfg_index <= REG_UNUSED;
        cfg_data  <= 9'($urandom_range(511));
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_and_settle();
        while (pending_reads.size() != 0)
            @(posedge clk);
        // a long rotation may still be walking the store
        repeat (ROT_SETTLE) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_pix = {stored_red, stored_green, stored_blue,
                       shown_red, shown_green, shown_blue};
            if (pending_reads.size() == 0)
            begin
                $display("%0t: unexpected read item %h", $time, got_pix);
                mismatch_count++;
            end
            else
            begin
                want_pix = pending_reads.pop_front();
                for (int k = 0; k < 6; k++)
                begin
                    if (got_pix[k] !== want_pix[k])
                    begin
                        $display("%0t: %s expected %0d got %0d", $time, field_names[k],
                                 want_pix[k], got_pix[k]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("tb_palette_rotate_tone_fade: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        for (int n = 0; n < prtf_pkg::ENTRIES_DEF; n++)
        begin
            pal_model[n] = '0;
            pal_written[n] = 1'b0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct = 6;
        recv_idle_pct = 81;
        foreach (DIRECTED[n])
            send_item(DIRECTED[n].op, DIRECTED[n].first, DIRECTED[n].last, DIRECTED[n].r,
                      DIRECTED[n].g, DIRECTED[n].b, DIRECTED[n].typed, DIRECTED[n].want);
        in_valid <= 1'b0;

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg == 2)
            begin
                send_gap_pct = 81;
                recv_idle_pct = 6;
            end
            else if (seg == 4)
            begin
                send_gap_pct = 0;
                recv_idle_pct = 0;
            end
            drain_and_settle();
            case (seg)
                0: program_tone(7'd37, 9'd200);
                1: program_tone(7'd100, 9'd256);
                2: program_tone(7'd127, 9'd511);
                3: program_tone(7'd0, 9'd0);
                4: program_tone(7'd64, 9'd300);
                default: program_tone(7'($urandom_range(127)), 9'($urandom_range(511)));
            endcase
            repeat (SEG_ITEMS) send_random();
            in_valid <= 1'b0;
        end

        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_palette_rotate_tone_fade: done, clean");
        else
            $display("tb_palette_rotate_tone_fade: done, errors");
        $finish;
    end

endmodule
